[rtl/core/wpc_pkg.sv]
// Shared package for the waveform pedestal and peak counter.
// Holds field widths, register indexes, reset values and the command,
// status and result types. Depends on nothing.
package wpc_pkg;

	// Default values for the top-level parameters.
	localparam int WAVEFORM_LENGTH_DEF      = 1024;
	localparam int MAX_PEDESTAL_SAMPLES_DEF = 256;
	localparam int SAMPLE_BITS_DEF          = 12;

	// Configuration register widths.
	localparam int PED_W   = 9;
	localparam int START_W = 10;
	localparam int END_W   = 11;
	localparam int SIGMA_W = 4;

	// Configuration register reset values.
	localparam logic [PED_W-1:0]   PED_RESET   = 9'd100;
	localparam logic [START_W-1:0] START_RESET = 10'd100;
	localparam logic [END_W-1:0]   END_RESET   = 11'd994;
	localparam logic [SIGMA_W-1:0] SIGMA_RESET = 4'd5;

	// Configuration write channel widths.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	// Register indexes on the configuration channel.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PED_SAMPLES  = 3'd0,
		CFG_SEARCH_START = 3'd1,
		CFG_SEARCH_END   = 3'd2,
		CFG_THRESHOLD    = 3'd3
	} cfg_reg_t;

	// Result field widths.
	localparam int PEAK_TIME_W  = 10;
	localparam int PEAK_COUNT_W = 10;
	localparam int PSUM_W       = 20;
	localparam int PSQ_W        = 32;

	localparam logic [PEAK_COUNT_W-1:0] PEAK_SAT = '1;

	// Result kinds.
	localparam logic KIND_PEAK    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Operand selection of the shared multiplier.
	typedef enum logic [3:0] {
		MUL_XX,   // sample squared
		MUL_NX,   // pedestal length times sample
		MUL_NSQ,  // pedestal length times square sum
		MUL_SS,   // sum squared
		MUL_NK,   // pedestal length times sigma multiple
		MUL_KKN,  // previous product times sigma multiple
		MUL_BND,  // spread times k*k*n
		MUL_DD,   // difference squared
		MUL_DDN   // squared difference times (n - 1)
	} mul_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    take_in;
		logic    mul_en;
		mul_op_t mul_op;
		logic    ped_acc;
		logic    save_prod;
		logic    save_spread;
		logic    save_diff;
		logic    save_bound;
		logic    eval;
		logic    finish;
	} wpc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_ped;
		logic is_last_ped;
		logic is_search;
		logic peak_new;
		logic last;
	} wpc_stat_t;

	// One result beat.
	typedef struct packed {
		logic                    kind;
		logic [PEAK_TIME_W-1:0]  peak_time;
		logic [PEAK_COUNT_W-1:0] peak_count;
		logic [PSUM_W-1:0]       pedestal_sum;
		logic [PSQ_W-1:0]        pedestal_square_sum;
		logic                    last_of_run;
	} wpc_result_t;

endpackage

[rtl/core/wpc_if.sv]
// Channel interfaces of the waveform pedestal and peak counter:
// sample input, result output and configuration write.
// Depends on wpc_pkg.
interface wpc_in_if #(
	parameter int SAMPLE_BITS = wpc_pkg::SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   end_of_waveform;

	modport source (output valid, sample, end_of_waveform, input ready);
	modport sink (input valid, sample, end_of_waveform, output ready);
endinterface

interface wpc_out_if;
	logic                             valid;
	logic                             ready;
	logic                             kind;
	logic [wpc_pkg::PEAK_TIME_W-1:0]  peak_time;
	logic [wpc_pkg::PEAK_COUNT_W-1:0] peak_count;
	logic [wpc_pkg::PSUM_W-1:0]       pedestal_sum;
	logic [wpc_pkg::PSQ_W-1:0]        pedestal_square_sum;
	logic                             last_of_run;

	modport source (output valid, kind, peak_time, peak_count, pedestal_sum,
		pedestal_square_sum, last_of_run, input ready);
	modport sink (input valid, kind, peak_time, peak_count, pedestal_sum,
		pedestal_square_sum, last_of_run, output ready);
endinterface

interface wpc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [wpc_pkg::CFG_IDX_W-1:0]  index;
	logic [wpc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/wpc_ctrl.sv]
// Controller of the waveform pedestal and peak counter: sequences the
// shared multiplier and the result beats for one sample at a time.
// Depends on wpc_pkg.
module wpc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output wpc_pkg::wpc_cmd_t cmd,
	input  wpc_pkg::wpc_stat_t stat
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PED_SQ,
		ST_PED_ACC,
		ST_BND_NS,
		ST_BND_SS,
		ST_BND_KN,
		ST_BND_KKN,
		ST_BND_MUL,
		ST_BND_LD,
		ST_SR_NX,
		ST_SR_D,
		ST_SR_DD,
		ST_SR_DDN,
		ST_SR_CMP,
		ST_FIN,
		ST_PEAK_OUT,
		ST_SUM_OUT
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;
	logic   accept;

	assign accept    = in_valid & in_ready_q;
	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	// State register with the handshake outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						in_ready_q <= 1'b0;
						if (stat.is_ped) begin
							state_q <= ST_PED_SQ;
						end else if (stat.is_search) begin
							state_q <= ST_SR_NX;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_PED_SQ:  state_q <= ST_PED_ACC;
				ST_PED_ACC: begin
					state_q <= stat.is_last_ped ? ST_BND_NS : ST_FIN;
				end
				ST_BND_NS:  state_q <= ST_BND_SS;
				ST_BND_SS:  state_q <= ST_BND_KN;
				ST_BND_KN:  state_q <= ST_BND_KKN;
				ST_BND_KKN: state_q <= ST_BND_MUL;
				ST_BND_MUL: state_q <= ST_BND_LD;
				ST_BND_LD:  state_q <= ST_FIN;
				ST_SR_NX:   state_q <= ST_SR_D;
				ST_SR_D:    state_q <= ST_SR_DD;
				ST_SR_DD:   state_q <= ST_SR_DDN;
				ST_SR_DDN:  state_q <= ST_SR_CMP;
				ST_SR_CMP: begin
					if (stat.peak_new) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_PEAK_OUT;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (stat.last) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_SUM_OUT;
					end else begin
						in_ready_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				ST_PEAK_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						state_q     <= ST_FIN;
					end
				end
				ST_SUM_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						in_ready_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command decode per state.
	always_comb begin
		cmd        = '0;
		cmd.mul_op = wpc_pkg::MUL_XX;
		unique case (state_q)
			ST_IDLE:    cmd.take_in = accept;
			ST_PED_SQ: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = wpc_pkg::MUL_XX;
			end
			ST_PED_ACC: cmd.ped_acc = 1'b1;
			ST_BND_NS: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = wpc_pkg::MUL_NSQ;
			end
			ST_BND_SS: begin
				cmd.save_prod = 1'b1;
				cmd.mul_en    = 1'b1;
				cmd.mul_op    = wpc_pkg::MUL_SS;
			end
			ST_BND_KN: begin
				cmd.save_spread = 1'b1;
				cmd.mul_en      = 1'b1;
				cmd.mul_op      = wpc_pkg::MUL_NK;
			end
			ST_BND_KKN: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = wpc_pkg::MUL_KKN;
			end
			ST_BND_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = wpc_pkg::MUL_BND;
			end
			ST_BND_LD:  cmd.save_bound = 1'b1;
			ST_SR_NX: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = wpc_pkg::MUL_NX;
			end
			ST_SR_D:    cmd.save_diff = 1'b1;
			ST_SR_DD: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = wpc_pkg::MUL_DD;
			end
			ST_SR_DDN: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = wpc_pkg::MUL_DDN;
			end
			ST_SR_CMP:  cmd.eval = 1'b1;
			ST_FIN:     cmd.finish = 1'b1;
			ST_PEAK_OUT, ST_SUM_OUT: begin
				cmd.mul_en = 1'b0;
			end
			default: begin
				cmd.mul_en = 1'b0;
			end
		endcase
	end

endmodule

[rtl/core/wpc_datapath.sv]
// Datapath of the waveform pedestal and peak counter: configuration
// registers, pedestal accumulators, shared multiplier and result register.
// Depends on wpc_pkg and wpc_cfg_if.
module wpc_datapath #(
	parameter int WAVEFORM_LENGTH      = wpc_pkg::WAVEFORM_LENGTH_DEF,
	parameter int MAX_PEDESTAL_SAMPLES = wpc_pkg::MAX_PEDESTAL_SAMPLES_DEF,
	parameter int SAMPLE_BITS          = wpc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	wpc_cfg_if.sink                  cfg,
	input  logic [SAMPLE_BITS-1:0]   in_sample,
	input  logic                     in_end,
	input  wpc_pkg::wpc_cmd_t        cmd,
	output wpc_pkg::wpc_stat_t       stat,
	output wpc_pkg::wpc_result_t     result
);

	localparam int N_W    = $clog2(MAX_PEDESTAL_SAMPLES + 1);
	localparam int IDX_W  = $clog2(WAVEFORM_LENGTH + 1);
	localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_PEDESTAL_SAMPLES);
	localparam int SQ_W   = 2 * SAMPLE_BITS + $clog2(MAX_PEDESTAL_SAMPLES);
	localparam int SPR_W  = N_W + SQ_W;
	localparam int KKN_W  = 2 * wpc_pkg::SIGMA_W + N_W;
	localparam int MA_W   = SPR_W;
	localparam int MB_W   = (SUM_W > KKN_W) ? SUM_W : KKN_W;
	localparam int P_W    = MA_W + MB_W;
	localparam int BND_W  = SPR_W + KKN_W;
	localparam int NC_W   = (N_W > wpc_pkg::PED_W) ? N_W : wpc_pkg::PED_W;
	localparam int CW0    = (IDX_W > wpc_pkg::END_W) ? IDX_W : wpc_pkg::END_W;
	localparam int CW     = (CW0 > NC_W) ? CW0 : NC_W;

	// Configuration registers.
	logic [wpc_pkg::PED_W-1:0]   ped_q;
	logic [wpc_pkg::START_W-1:0] start_q;
	logic [wpc_pkg::END_W-1:0]   end_q;
	logic [wpc_pkg::SIGMA_W-1:0] sigma_q;

	// Waveform state.
	logic [IDX_W-1:0] idx_q;
	logic [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]  sq_q;
	logic [BND_W-1:0] bound_q;
	logic             in_peak_q;
	logic [wpc_pkg::PEAK_COUNT_W-1:0] peaks_q;

	// Per-sample working registers.
	logic [SAMPLE_BITS-1:0] x_q;
	logic                   last_q;
	logic [P_W-1:0]         prod_q;
	logic [SPR_W-1:0]       tmp_q;
	logic                   neg_q;
	wpc_pkg::wpc_result_t   res_q;

	logic [NC_W-1:0] n_ext;
	logic [N_W-1:0]  n_w;
	logic [CW-1:0]   idx_c;
	logic [CW-1:0]   n_c;
	logic            in_range;
	logic            below;
	logic            peak_new;
	logic [MA_W-1:0] a_op;
	logic [MB_W-1:0] b_op;
	logic [P_W-1:0]  prod_full;

	assign cfg.ready = 1'b1;

	// Register writes from the configuration channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ped_q   <= wpc_pkg::PED_RESET;
			start_q <= wpc_pkg::START_RESET;
			end_q   <= wpc_pkg::END_RESET;
			sigma_q <= wpc_pkg::SIGMA_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				wpc_pkg::CFG_PED_SAMPLES:  ped_q   <= cfg.data[wpc_pkg::PED_W-1:0];
				wpc_pkg::CFG_SEARCH_START: start_q <= cfg.data[wpc_pkg::START_W-1:0];
				wpc_pkg::CFG_SEARCH_END:   end_q   <= cfg.data[wpc_pkg::END_W-1:0];
				wpc_pkg::CFG_THRESHOLD:    sigma_q <= cfg.data[wpc_pkg::SIGMA_W-1:0];
				default: begin
					ped_q <= ped_q;
				end
			endcase
		end
	end

	// Pedestal length clamped to its legal range.
	always_comb begin
		n_ext = NC_W'(ped_q);
		if (n_ext < NC_W'(2)) begin
			n_ext = NC_W'(2);
		end else if (n_ext > NC_W'(MAX_PEDESTAL_SAMPLES)) begin
			n_ext = NC_W'(MAX_PEDESTAL_SAMPLES);
		end
	end
	assign n_w = N_W'(n_ext);

	// Classification of the current sample index.
	assign idx_c    = CW'(idx_q);
	assign n_c      = CW'(n_w);
	assign in_range = idx_c < CW'(WAVEFORM_LENGTH);

	assign stat.is_ped      = in_range && (idx_c < n_c);
	assign stat.is_last_ped = idx_c == (n_c - CW'(1));
	assign stat.is_search   = in_range && !(idx_c < n_c) && (idx_c >= CW'(start_q))
		&& (idx_c < CW'(end_q));
	assign stat.peak_new    = peak_new;
	assign stat.last        = last_q;

	// Threshold test on the finished product d*d*(n-1).
	assign below    = !neg_q && (prod_q >= P_W'(bound_q));
	assign peak_new = !in_peak_q && below;

	// Operand selection of the shared multiplier.
	always_comb begin
		a_op = '0;
		b_op = '0;
		case (cmd.mul_op)
			wpc_pkg::MUL_XX: begin
				a_op = MA_W'(x_q);
				b_op = MB_W'(x_q);
			end
			wpc_pkg::MUL_NX: begin
				a_op = MA_W'(n_w);
				b_op = MB_W'(x_q);
			end
			wpc_pkg::MUL_NSQ: begin
				a_op = MA_W'(sq_q);
				b_op = MB_W'(n_w);
			end
			wpc_pkg::MUL_SS: begin
				a_op = MA_W'(sum_q);
				b_op = MB_W'(sum_q);
			end
			wpc_pkg::MUL_NK: begin
				a_op = MA_W'(n_w);
				b_op = MB_W'(sigma_q);
			end
			wpc_pkg::MUL_KKN: begin
				a_op = MA_W'(prod_q[KKN_W-1:0]);
				b_op = MB_W'(sigma_q);
			end
			wpc_pkg::MUL_BND: begin
				a_op = tmp_q;
				b_op = MB_W'(prod_q[KKN_W-1:0]);
			end
			wpc_pkg::MUL_DD: begin
				a_op = tmp_q;
				b_op = MB_W'(tmp_q[SUM_W-1:0]);
			end
			wpc_pkg::MUL_DDN: begin
				a_op = MA_W'(prod_q[2*SUM_W-1:0]);
				b_op = MB_W'(n_w - N_W'(1));
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
	end
	assign prod_full = P_W'(a_op) * P_W'(b_op);

	// Working registers: sample latch, product, difference and result.
	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			x_q    <= in_sample;
			last_q <= in_end;
		end
		if (cmd.mul_en) begin
			prod_q <= prod_full;
		end
		if (cmd.save_prod) begin
			tmp_q <= SPR_W'(prod_q);
		end
		if (cmd.save_spread) begin
			tmp_q <= tmp_q - SPR_W'(prod_q);
		end
		if (cmd.save_diff) begin
			neg_q <= P_W'(sum_q) < prod_q;
			tmp_q <= SPR_W'(sum_q - SUM_W'(prod_q));
		end
		if (cmd.eval && peak_new) begin
			res_q.kind                <= wpc_pkg::KIND_PEAK;
			res_q.peak_time           <= wpc_pkg::PEAK_TIME_W'(idx_q);
			res_q.peak_count          <= '0;
			res_q.pedestal_sum        <= '0;
			res_q.pedestal_square_sum <= '0;
			res_q.last_of_run         <= !last_q;
		end
		if (cmd.finish && last_q) begin
			res_q.kind                <= wpc_pkg::KIND_SUMMARY;
			res_q.peak_time           <= '0;
			res_q.peak_count          <= peaks_q;
			res_q.pedestal_sum        <= wpc_pkg::PSUM_W'(sum_q);
			res_q.pedestal_square_sum <= wpc_pkg::PSQ_W'(sq_q);
			res_q.last_of_run         <= 1'b1;
		end
	end
	assign result = res_q;

	// Waveform state: index, accumulators, bound and peak tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			sum_q     <= '0;
			sq_q      <= '0;
			bound_q   <= '0;
			in_peak_q <= 1'b0;
			peaks_q   <= '0;
		end else begin
			if (cmd.ped_acc) begin
				sum_q <= sum_q + SUM_W'(x_q);
				sq_q  <= sq_q + SQ_W'(prod_q);
			end
			if (cmd.save_bound) begin
				bound_q <= BND_W'(prod_q);
			end
			if (cmd.eval) begin
				if (in_peak_q) begin
					if (!below) begin
						in_peak_q <= 1'b0;
					end
				end else if (below) begin
					in_peak_q <= 1'b1;
					if (peaks_q != wpc_pkg::PEAK_SAT) begin
						peaks_q <= peaks_q + wpc_pkg::PEAK_COUNT_W'(1);
					end
				end
			end
			if (cmd.finish) begin
				if (last_q) begin
					idx_q     <= '0;
					sum_q     <= '0;
					sq_q      <= '0;
					bound_q   <= '0;
					in_peak_q <= 1'b0;
					peaks_q   <= '0;
				end else if (in_range) begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

endmodule

[rtl/core/waveform_pedestal_peak_counter_unit.sv]
// Top level of the waveform pedestal and peak counter.
// Joins the controller and the datapath to the three channels.
// Depends on wpc_pkg, wpc_if, wpc_ctrl and wpc_datapath.
//
//   channel   direction  beat contents
//   samples   in         sample, end_of_waveform
//   results   out        kind, peak_time, peak_count, pedestal_sum,
//                        pedestal_square_sum, last_of_run
//   cfg       in         index, data (register write)
//
// One sample is handled at a time, all products going through a single
// shared multiplier. A sample outside the pedestal and the search window
// goes straight to the finish step; a pedestal sample is squared and
// accumulated (the last pedestal sample also forms the variance bound) and
// a window sample is tested against the bound. A result beat waits for results.ready.
// Reset clears the waveform state and loads the register defaults; no
// sample is taken while a result beat waits. Configuration beats are taken
// in every cycle.
module waveform_pedestal_peak_counter_unit #(
	parameter int WAVEFORM_LENGTH      = wpc_pkg::WAVEFORM_LENGTH_DEF,
	parameter int MAX_PEDESTAL_SAMPLES = wpc_pkg::MAX_PEDESTAL_SAMPLES_DEF,
	parameter int SAMPLE_BITS          = wpc_pkg::SAMPLE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	wpc_in_if.sink     samples,
	wpc_out_if.source  results,
	wpc_cfg_if.sink    cfg
);

	wpc_pkg::wpc_cmd_t    cmd;
	wpc_pkg::wpc_stat_t   stat;
	wpc_pkg::wpc_result_t result;

	// Sequencer for one sample and its result beats.
	wpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Arithmetic, state and result register.
	wpc_datapath #(
		.WAVEFORM_LENGTH      (WAVEFORM_LENGTH),
		.MAX_PEDESTAL_SAMPLES (MAX_PEDESTAL_SAMPLES),
		.SAMPLE_BITS          (SAMPLE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_sample (samples.sample),
		.in_end    (samples.end_of_waveform),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

	// Result beat payload.
	assign results.kind                = result.kind;
	assign results.peak_time           = result.peak_time;
	assign results.peak_count          = result.peak_count;
	assign results.pedestal_sum        = result.pedestal_sum;
	assign results.pedestal_square_sum = result.pedestal_square_sum;
	assign results.last_of_run         = result.last_of_run;

endmodule
